>>> rtl/reply_frame_crc_checker_unit_defines.svh
// Assertion macros shared by the reply frame CRC checker RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef REPLY_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH
`define REPLY_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge.
`define RFCC_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("rfcc: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RFCC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("rfcc: next-cycle check failed");

`else

`define RFCC_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define RFCC_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

>>> rtl/rfcc_pkg.sv
// Types, constants and CRC-16 nibble functions for the reply frame CRC checker.
// No dependencies.
package rfcc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Polynomial 0x1021 multiplied by each possible top nibble.
    localparam logic [15:0] NIB_TABLE [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063,
        16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
        16'h8108, 16'h9129, 16'ha14a, 16'hb16b,
        16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
    };

    typedef struct packed {
        logic        crc_ok;
        logic        too_short;
        logic [15:0] crc_value;
    } result_t;

    // Shift the data nibble into the low end, fold the top nibble back in.
    function automatic logic [15:0] crc_nib_step(input logic [15:0] c, input logic [3:0] nib);
        return {c[11:0], nib} ^ NIB_TABLE[c[15:12]];
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        return crc_nib_step(crc_nib_step(c, b[7:4]), b[3:0]);
    endfunction

endpackage

>>> rtl/rfcc_frame_core.sv
// Frame state of the reply frame CRC checker: byte count, two-byte trailer
// delay, running CRC and the end-of-frame verdict. Depends on rfcc_pkg.
`include "reply_frame_crc_checker_unit_defines.svh"

module rfcc_frame_core
    import rfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output result_t     result
);

    typedef enum logic [1:0] {
        CNT_EMPTY,
        CNT_HEADER,
        CNT_ONE_HELD,
        CNT_TWO_HELD
    } count_t;

    count_t      count_reg,  count_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  held0_reg,  held0_next;
    logic [7:0]  held1_reg,  held1_next;
    logic        short_frame;

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        case (count_reg)
            CNT_EMPTY:
            begin
                count_next = CNT_HEADER;
            end
            CNT_HEADER:
            begin
                held0_next = rx_byte;
                count_next = CNT_ONE_HELD;
            end
            CNT_ONE_HELD:
            begin
                held1_next = held0_reg;
                held0_next = rx_byte;
                count_next = CNT_TWO_HELD;
            end
            default:
            begin
                // Oldest held byte is now known to be body: fold it in.
                crc_next   = crc_byte(crc_reg, held1_reg);
                held1_next = held0_reg;
                held0_next = rx_byte;
            end
        endcase
    end

    assign short_frame = (count_reg == CNT_EMPTY) || (count_reg == CNT_HEADER);

    always_comb
    begin
        if (short_frame)
        begin
            result.crc_ok    = 1'b0;
            result.too_short = 1'b1;
            result.crc_value = CRC_INIT;
        end
        else
        begin
            result.crc_ok    = ({held1_next, held0_next} == crc_next);
            result.too_short = 1'b0;
            result.crc_value = crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_EMPTY;
            crc_reg   <= CRC_INIT;
            held0_reg <= '0;
            held1_reg <= '0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                // Drop all frame state for the next frame.
                count_reg <= CNT_EMPTY;
                crc_reg   <= CRC_INIT;
                held0_reg <= '0;
                held1_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                held0_reg <= held0_next;
                held1_reg <= held1_next;
            end
        end
    end

    `RFCC_ASSERT_NEXT(a_end_clears_count, clk, rst_n, step && frame_end, count_reg == CNT_EMPTY)
    `RFCC_ASSERT_IMPLIES(a_crc_idle_early, clk, rst_n, count_reg != CNT_TWO_HELD, crc_reg == CRC_INIT)
    `RFCC_ASSERT_IMPLIES(a_short_fails, clk, rst_n, result.too_short, !result.crc_ok)
    `RFCC_ASSERT_NEXT(a_count_holds, clk, rst_n, !step, $stable(count_reg) && $stable(crc_reg))

endmodule

>>> rtl/reply_frame_crc_checker_unit.sv
// Top level of the reply frame CRC checker: input register, frame core and
// result register. Depends on rfcc_pkg and rfcc_frame_core.
//
// Takes one reply frame byte per cycle on the in_valid/in_ready channel and
// gives one result, on the out_valid/out_ready channel, for each byte marked
// frame_end. A byte is registered at the input, then enters the frame core's
// trailer delay and two-nibble CRC update and, if it ends the frame, lands in
// the result register. The sustained rate is one byte per cycle; in_ready
// drops only while a frame-end byte sits in the input register and the result
// register still holds an earlier request that out_ready has not taken.
`include "reply_frame_crc_checker_unit_defines.svh"

module reply_frame_crc_checker_unit
    import rfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        crc_ok,
    output logic        too_short,
    output logic [15:0] crc_value
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    core_result;
    logic       out_free;
    logic       s1_fire;
    logic       out_load;

    assign out_free = !out_valid_reg || out_ready;
    // A byte that yields no result never waits on the output side.
    assign s1_fire  = s1_valid_reg && (!s1_end_reg || out_free);
    assign out_load = s1_fire && s1_end_reg;
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
            s1_end_reg  <= frame_end;
        end
    end

    rfcc_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .rx_byte   (s1_byte_reg),
        .frame_end (s1_end_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_ok    = out_result_reg.crc_ok;
    assign too_short = out_result_reg.too_short;
    assign crc_value = out_result_reg.crc_value;

    `RFCC_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !out_load)
    `RFCC_ASSERT_NEXT(a_body_byte_moves, clk, rst_n, s1_valid_reg && !s1_end_reg, in_ready || s1_valid_reg)
    `RFCC_ASSERT_NEXT(a_end_gives_result, clk, rst_n, out_load, out_valid_reg)

endmodule

>>> verif/tb_reply_frame_crc_checker_unit.sv
// Testbench for reply_frame_crc_checker_unit: directed frames, then random frames
// checked against a behavioral CRC-16 frame predictor. Depends on rfcc_pkg and the RTL.
module tb_reply_frame_crc_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rfcc_pkg::*;

    localparam int RANDOM_REQUESTS = 500;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam result_t NO_VERDICT   = '0;
    localparam result_t SHORT_FRAME  = '{crc_ok: 1'b0, too_short: 1'b1, crc_value: CRC_INIT};
    localparam result_t EMPTY_PASS   = '{crc_ok: 1'b1, too_short: 1'b0, crc_value: CRC_INIT};
    localparam result_t EMPTY_FAIL   = '{crc_ok: 1'b0, too_short: 1'b0, crc_value: CRC_INIT};

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    verdict;
    } frame_row_t;

    localparam int DIRECTED_ROWS = 19;
    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, SHORT_FRAME},
        '{8'hFF, 1'b1, 1'b1, SHORT_FRAME},
        '{8'hAA, 1'b0, 1'b0, NO_VERDICT},
        '{8'h55, 1'b1, 1'b1, SHORT_FRAME},
        '{8'h00, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b1, 1'b1, EMPTY_PASS},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'h00, 1'b0, 1'b0, NO_VERDICT},
        '{8'h00, 1'b1, 1'b1, EMPTY_FAIL},
        '{8'h7E, 1'b0, 1'b0, NO_VERDICT},
        '{8'h00, 1'b0, 1'b0, NO_VERDICT},
        '{8'h12, 1'b0, 1'b0, NO_VERDICT},
        '{8'h34, 1'b1, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b1, 1'b0, NO_VERDICT}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    logic        crc_ok;
    logic        too_short;
    logic [15:0] crc_value;

    // Sideband held with each request: typed verdict for directed rows.
    logic        row_typed = 1'b0;
    result_t     row_verdict = '0;

    // Predictor state.
    logic [15:0] crc_acc = CRC_INIT;
    logic [1:0]  seen_cnt = '0;
    logic [7:0]  held_new = '0;
    logic [7:0]  held_old = '0;
    result_t     pending_verdicts [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    int requests_sent = 0;
    int verdicts_checked = 0;
    int short_seen = 0;
    int pass_seen = 0;
    int mismatches = 0;

    always #2 clk = ~clk;

    reply_frame_crc_checker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_ok    (crc_ok),
        .too_short (too_short),
        .crc_value (crc_value)
    );

    // Feed the byte in high nibble first; fold the carried-out nibble back via the polynomial.
    function automatic logic [15:0] crc_after_byte(input logic [15:0] c, input logic [7:0] b);
        logic [3:0]  top;
        logic [15:0] fold;
        for (int n = 1; n >= 0; n--)
        begin
            top = c[15:12];
            fold = '0;
            for (int i = 0; i < 4; i++)
            begin
                if (top[i])
                    fold = fold ^ (CRC_POLY << i);
            end
            c = {c[11:0], b[n*4 +: 4]} ^ fold;
        end
        return c;
    endfunction

    task take_frame_byte(input logic [7:0] b, input logic last, input logic typed,
                         input result_t typed_verdict);
        result_t v;
        case (seen_cnt)
            2'd0: seen_cnt = 2'd1;
            2'd1:
            begin
                held_new = b;
                seen_cnt = 2'd2;
            end
            2'd2:
            begin
                held_old = held_new;
                held_new = b;
                seen_cnt = 2'd3;
            end
            default:
            begin
                crc_acc = crc_after_byte(crc_acc, held_old);
                held_old = held_new;
                held_new = b;
            end
        endcase
        if (last)
        begin
            if (seen_cnt < 2'd3)
                v = SHORT_FRAME;
            else
            begin
                v.crc_ok = ({held_old, held_new} == crc_acc);
                v.too_short = 1'b0;
                v.crc_value = crc_acc;
            end
            pending_verdicts.push_back(typed ? typed_verdict : v);
            crc_acc = CRC_INIT;
            seen_cnt = '0;
            held_new = '0;
            held_old = '0;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                take_frame_byte(rx_byte, frame_end, row_typed, row_verdict);
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result ok=%0b short=%0b crc=%04h",
                             $time, crc_ok, too_short, crc_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    verdicts_checked++;
                    if (want.too_short)
                        short_seen++;
                    if (want.crc_ok)
                        pass_seen++;
                    if (crc_ok !== want.crc_ok)
                    begin
                        $display("%0t: crc_ok expected %0b actual %0b",
                                 $time, want.crc_ok, crc_ok);
                        mismatches++;
                    end
                    if (too_short !== want.too_short)
                    begin
                        $display("%0t: too_short expected %0b actual %0b",
                                 $time, want.too_short, too_short);
                        mismatches++;
                    end
                    if (crc_value !== want.crc_value)
                    begin
                        $display("%0t: crc_value expected %04h actual %04h",
                                 $time, want.crc_value, crc_value);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Receiver: a long hold-off takes priority over random stalls.
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic last, input logic typed,
                              input result_t typed_verdict);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_end <= last;
        row_typed <= typed;
        row_verdict <= typed_verdict;
        // Hold the request until it is taken.
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_random_frame();
        int kind;
        int body_len;
        logic [15:0] c;
        logic [15:0] trailer;
        logic [7:0] b;
        logic last;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            body_len = $urandom_range(1, 2);
            for (int i = 1; i <= body_len; i++)
                offer_byte(8'($urandom_range(255)), i == body_len, 1'b0, NO_VERDICT);
        end
        else if (kind < 16)
        begin
            // Noise: random bytes, frame end anywhere.
            do
            begin
                b = 8'($urandom_range(255));
                last = ($urandom_range(3) == 0);
                offer_byte(b, last, 1'b0, NO_VERDICT);
            end
            while (!last);
        end
        else
        begin
            body_len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            offer_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_VERDICT);
            c = CRC_INIT;
            repeat (body_len)
            begin
                b = 8'($urandom_range(255));
                c = crc_after_byte(c, b);
                offer_byte(b, 1'b0, 1'b0, NO_VERDICT);
            end
            kind = $urandom_range(99);
            if (kind < 75)
                trailer = c;
            else if (kind < 90)
                trailer = c ^ (16'h1 << $urandom_range(15));
            else
                trailer = 16'($urandom_range(16'hFFFF));
            offer_byte(trailer[15:8], 1'b0, 1'b0, NO_VERDICT);
            offer_byte(trailer[7:0], 1'b1, 1'b0, NO_VERDICT);
        end
    endtask

    task automatic drain_results();
        wait (pending_verdicts.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        #200_000;
        $display("timeout with %0d results outstanding", pending_verdicts.size());
        $display("tb_reply_frame_crc_checker_unit failed");
        $finish;
    end

    initial
    begin : stimulus
        int random_start;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        frame_end = 1'b0;
        out_ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 50;
        foreach (directed_rows[i])
            offer_byte(directed_rows[i].data, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].verdict);
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_REQUESTS)
        begin
            if (requests_sent - random_start < RANDOM_REQUESTS / 3)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 50;
            end
            else if (requests_sent - random_start < 2 * RANDOM_REQUESTS / 3)
            begin
                tx_idle_pct = 50;
                rx_idle_pct = 10;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_frame();
        end

        // Back up the result path with one-byte frames while the receiver holds off.
        drain_results();
        rx_hold_left = 160;
        repeat (24)
            offer_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_VERDICT);
        repeat (6)
            send_random_frame();
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending_verdicts.size() == 0);
        repeat (8) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
            mismatches++;
        end

        $display("sent %0d byte requests; checked %0d frame results (%0d short, %0d crc matches)",
                 requests_sent, verdicts_checked, short_seen, pass_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("tb_reply_frame_crc_checker_unit passed");
        else
            $display("tb_reply_frame_crc_checker_unit failed");
        $finish;
    end

endmodule
